// ===== hdl/rtb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared sizes, operation codes and transaction types for the repeating
// timer bank.
// ----------------------------------------------------------------------------
package rtb_pkg;

    // bank size and derived index width
    localparam int NUM_TIMERS = 8;
    localparam int TMR_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 3;
    localparam int TICK_W = 32;
    localparam int REP_W  = 8;
    localparam int EVT_W  = 16;

    // queue sizes (powers of two)
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2
    } op_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } back_state_t;

    // classified command held between front and back
    typedef struct packed {
        op_t               op;
        logic [TMR_W-1:0]  idx;
        logic [TICK_W-1:0] ticks;
        logic [REP_W-1:0]  reps;
        logic [EVT_W-1:0]  evt;
    } cmd_t;

    // one firing transaction
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [EVT_W-1:0] evt;
        logic             last;
    } result_t;

    // back end status
    typedef struct packed {
        logic busy;
        logic walking;
    } back_stat_t;

endpackage

// ===== hdl/rtb_front.sv =====
// ----------------------------------------------------------------------------
// rtb_front
// Accepts input transactions, drops ignored ones and queues the rest as
// classified commands for the back end.
// ----------------------------------------------------------------------------
module rtb_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rtb_pkg::FUNC_W-1:0] func,
    input  logic [rtb_pkg::IDX_W-1:0]  timer_index,
    input  logic [rtb_pkg::TICK_W-1:0] elapsed_ticks,
    input  logic [rtb_pkg::TICK_W-1:0] period,
    input  logic [rtb_pkg::REP_W-1:0]  repeat_count,
    input  logic [rtb_pkg::EVT_W-1:0]  event_code,
    input  logic                       cmd_pop,
    output logic                       cmd_empty,
    output rtb_pkg::cmd_t              cmd_head
);
    import rtb_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;

    logic                   keep;
    logic                   wr_en;
    logic                   rd_en;
    logic [TMR_W+IDX_W-1:0] idx_ext;
    cmd_t                   cmd_in;

    // classify: func 3 and out of range arm/disarm are dropped
    always_comb
    begin
        idx_ext      = {{TMR_W{1'b0}}, timer_index};
        cmd_in.op    = op_t'(func);
        cmd_in.idx   = idx_ext[TMR_W-1:0];
        cmd_in.reps  = repeat_count;
        cmd_in.evt   = event_code;
        cmd_in.ticks = period;
        keep         = 1'b0;
        unique case (func)
            OP_TICK:
            begin
                cmd_in.ticks = elapsed_ticks;
                keep         = 1'b1;
            end
            OP_ARM, OP_DISARM:
            begin
                keep = (int'(timer_index) < NUM_TIMERS);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // queue control
    assign full      = (count_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign cmd_empty = (count_reg == '0);
    assign cmd_head  = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full && keep;
    assign rd_en     = cmd_pop && !cmd_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + CMDQ_PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + CMDQ_PTR_W'(rd_en);
        count_next  = count_reg + (CMDQ_PTR_W+1)'(wr_en) - (CMDQ_PTR_W+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== hdl/rtb_back.sv =====
// ----------------------------------------------------------------------------
// rtb_back
// Carries out queued commands: arm and disarm when popped, tick by walking the
// timers one per cycle unless the result queue is full; each firing is queued.
// ----------------------------------------------------------------------------
module rtb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  rtb_pkg::cmd_t       cmd_head,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output rtb_pkg::result_t    res_data,
    output rtb_pkg::back_stat_t stat
);
    import rtb_pkg::*;

    localparam logic [TMR_W-1:0] LAST_PTR = TMR_W'(NUM_TIMERS - 1);

    // timer entries
    logic              active_reg [NUM_TIMERS];
    logic [TICK_W-1:0] reload_reg [NUM_TIMERS];
    logic [TICK_W-1:0] remain_reg [NUM_TIMERS];
    logic [REP_W-1:0]  reps_reg   [NUM_TIMERS];
    logic [EVT_W-1:0]  evt_reg    [NUM_TIMERS];

    back_state_t       state_reg, state_next;
    logic [TMR_W-1:0]  ptr_reg, ptr_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [TMR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [EVT_W-1:0]  pend_evt_reg, pend_evt_next;

    logic              arm_we;
    logic              tick_we;
    logic [TICK_W-1:0] remain_wdata;
    logic [REP_W-1:0]  reps_wdata;
    logic              act_we;
    logic [TMR_W-1:0]  act_addr;
    logic              act_val;

    logic              cur_active;
    logic [TICK_W-1:0] cur_remain;
    logic [REP_W-1:0]  cur_reps;
    logic              fire;
    logic [TMR_W+IDX_W-1:0] pend_idx_ext;

    assign cur_active   = active_reg[ptr_reg];
    assign cur_remain   = remain_reg[ptr_reg];
    assign cur_reps     = reps_reg[ptr_reg];
    assign fire         = (cur_remain <= elapsed_reg);
    assign pend_idx_ext = {{IDX_W{1'b0}}, pend_idx_reg};

    assign stat.busy    = (state_reg != ST_IDLE);
    assign stat.walking = (state_reg == ST_WALK);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        pend_idx_reg <= pend_idx_next;
        pend_evt_reg <= pend_evt_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        elapsed_next    = elapsed_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_evt_next   = pend_evt_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_data.index  = pend_idx_ext[IDX_W-1:0];
        res_data.evt    = pend_evt_reg;
        res_data.last   = 1'b0;
        arm_we          = 1'b0;
        tick_we         = 1'b0;
        remain_wdata    = cur_remain - elapsed_reg;
        reps_wdata      = cur_reps;
        act_we          = 1'b0;
        act_addr        = cmd_head.idx;
        act_val         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_head.op)
                        OP_ARM:
                        begin
                            arm_we  = 1'b1;
                            act_we  = 1'b1;
                            act_val = 1'b1;
                        end
                        OP_DISARM:
                        begin
                            act_we  = 1'b1;
                            act_val = 1'b0;
                        end
                        OP_TICK:
                        begin
                            elapsed_next = cmd_head.ticks;
                            ptr_next     = '0;
                            state_next   = ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // one timer per cycle, held while the result queue is full
                if (!res_full)
                begin
                    if (cur_active)
                    begin
                        tick_we = 1'b1;
                        if (fire)
                        begin
                            // earlier firing is now known not to be the last
                            res_push        = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_idx_next   = ptr_reg;
                            pend_evt_next   = evt_reg[ptr_reg];
                            remain_wdata    = reload_reg[ptr_reg];
                            if (cur_reps != '0)
                            begin
                                reps_wdata = cur_reps - REP_W'(1);
                                if (cur_reps == REP_W'(1))
                                begin
                                    act_we   = 1'b1;
                                    act_addr = ptr_reg;
                                    act_val  = 1'b0;
                                end
                            end
                        end
                    end
                    if (ptr_reg == LAST_PTR)
                    begin
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + TMR_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                // final firing of this tick
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    res_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // active flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                active_reg[i] <= 1'b0;
            end
        end
        else if (act_we)
        begin
            active_reg[act_addr] <= act_val;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (arm_we)
        begin
            reload_reg[cmd_head.idx] <= cmd_head.ticks;
            remain_reg[cmd_head.idx] <= cmd_head.ticks;
            reps_reg[cmd_head.idx]   <= cmd_head.reps;
            evt_reg[cmd_head.idx]    <= cmd_head.evt;
        end
        else if (tick_we)
        begin
            remain_reg[ptr_reg] <= remain_wdata;
            reps_reg[ptr_reg]   <= reps_wdata;
        end
    end

endmodule

// ===== hdl/rtb_out_queue.sv =====
// ----------------------------------------------------------------------------
// rtb_out_queue
// Result queue between the back end and the output ports.
// ----------------------------------------------------------------------------
module rtb_out_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      res_push,
    input  rtb_pkg::result_t          res_data,
    output logic                      res_full,
    output logic                      empty,
    input  logic                      pop,
    output logic [rtb_pkg::IDX_W-1:0] fired_index,
    output logic [rtb_pkg::EVT_W-1:0] fired_event,
    output logic                      last
);
    import rtb_pkg::*;

    result_t               q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_PTR_W:0]   count_reg, count_next;
    logic                  wr_en;
    logic                  rd_en;
    result_t               head;

    // queue control
    assign res_full    = (count_reg == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
    assign empty       = (count_reg == '0);
    assign wr_en       = res_push && !res_full;
    assign rd_en       = pop && !empty;
    assign head        = q_reg[rd_ptr_reg];
    assign fired_index = head.index;
    assign fired_event = head.evt;
    assign last        = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(rd_en);
        count_next  = count_reg + (OUTQ_PTR_W+1)'(wr_en) - (OUTQ_PTR_W+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ===== hdl/repeating_timer_bank.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_bank
// Arm and disarm are carried out as the back end pops them; a tick walks the
// timers one per cycle while the result queue has room, then issues its final
// firing from a flush state when the walk found any firing timer.
// The back end takes the next command only after a tick's walk and flush end;
// the front queue can still accept commands while a tick is being walked.
// Reset clears all timers to inactive and empties both queues.
// ----------------------------------------------------------------------------
module repeating_timer_bank (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rtb_pkg::FUNC_W-1:0] func,
    input  logic [rtb_pkg::IDX_W-1:0]  timer_index,
    input  logic [rtb_pkg::TICK_W-1:0] elapsed_ticks,
    input  logic [rtb_pkg::TICK_W-1:0] period,
    input  logic [rtb_pkg::REP_W-1:0]  repeat_count,
    input  logic [rtb_pkg::EVT_W-1:0]  event_code,
    output logic                       empty,
    input  logic                       pop,
    output logic [rtb_pkg::IDX_W-1:0]  fired_index,
    output logic [rtb_pkg::EVT_W-1:0]  fired_event,
    output logic                       last
);
    import rtb_pkg::*;

    logic       cmd_pop;
    logic       cmd_empty;
    cmd_t       cmd_head;
    logic       res_push;
    logic       res_full;
    result_t    res_data;
    back_stat_t stat;

    // front: accept and classify
    rtb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .timer_index   (timer_index),
        .elapsed_ticks (elapsed_ticks),
        .period        (period),
        .repeat_count  (repeat_count),
        .event_code    (event_code),
        .cmd_pop       (cmd_pop),
        .cmd_empty     (cmd_empty),
        .cmd_head      (cmd_head)
    );

    // back: execute commands and walk timers
    rtb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .stat      (stat)
    );

    // result queue
    rtb_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_push    (res_push),
        .res_data    (res_data),
        .res_full    (res_full),
        .empty       (empty),
        .pop         (pop),
        .fired_index (fired_index),
        .fired_event (fired_event),
        .last        (last)
    );

    // no firing transaction is lost to a full result queue
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // back end only pops commands that exist
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // a tick command starts a walk
    a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd_head.op == OP_TICK)) |=> stat.walking)
        else $error("tick did not start a walk");

    // results are only produced during a tick
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> !res_push)
        else $error("result pushed while idle");

endmodule
